>>> rtl/cbq_pkg.sv
// Shared types and sizing constants for the calendar bucket queue.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none

package cbq_pkg;

   // Queue geometry
   localparam int NumBuckets  = 1024;
   localparam int BucketDepth = 8;
   localparam int TimeBits    = 48;
   localparam int ValueBits   = 32;

   localparam int BucketBits = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int HeadBits   = (BucketDepth > 1) ? $clog2(BucketDepth) : 1;
   localparam int CountBits  = $clog2(BucketDepth + 1);
   localparam int SlotTotal  = NumBuckets * BucketDepth;
   localparam int SlotBits   = $clog2(SlotTotal);
   localparam int TotalBits  = $clog2(SlotTotal + 1);
   localparam int SlotWidth  = TimeBits + ValueBits;

   // Response status codes
   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusEmpty = 2'd1;
   localparam logic [1:0] StatusFull  = 2'd2;

   // Request command codes
   localparam logic CmdPush = 1'b0;
   localparam logic CmdPop  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [47:0]        item_time;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [47:0]        out_time;
      logic signed [31:0] out_value;
      logic [13:0]        occupancy;
   } rsp_type;

   // Per-bucket bookkeeping held in the bucket table
   typedef struct packed {
      logic [HeadBits-1:0]  head;
      logic [CountBits-1:0] count;
   } meta_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_write;  // write zero to the bucket entry under the sweep counter
      logic load_req;     // capture request, read bucket entry at the pointer
      logic scan_read;    // read bucket entry at the pointer
      logic scan_step;    // advance the pointer, wrapping
      logic scan_hit;     // capture the front slot index of the pointer's bucket
      logic lookup;       // read target bucket entry (the pointer's on a pop) and the front slot
      logic commit;       // write back state and load the response register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;   // sweep counter at the last bucket
      logic queue_empty;  // no records held
      logic bucket_busy;  // bucket entry just read holds records
      logic out_free;     // response register can take a new transaction
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/cbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module cbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/cbq_ctrl.sv
// Sequencing state machine for the calendar bucket queue.
// Depends on cbq_pkg for the command and status structs.
`default_nettype none

module cbq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire cbq_pkg::dp_stat_type stat,
   output cbq_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_SCAN_CHK = 6'b000100,
      ST_SCAN_RD  = 6'b001000,
      ST_LOOKUP   = 6'b010000,
      ST_COMMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = stat.queue_empty ? ST_LOOKUP : ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.bucket_busy) begin
               cmd.scan_hit = 1'b1;
               state_in     = ST_LOOKUP;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CHK;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the response register is free
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cbq_datapath.sv
// Datapath of the calendar bucket queue: bucket table, slot store, pointer,
// record count and response register. Depends on cbq_pkg and cbq_ram.
`default_nettype none

module cbq_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cbq_pkg::req_type     req_payload,
   input  wire logic                 rsp_ready,
   input  wire cbq_pkg::ctl_cmd_type cmd,
   output cbq_pkg::dp_stat_type      stat,
   output logic                      rsp_valid,
   output cbq_pkg::rsp_type          rsp_payload
);

   localparam int BB = cbq_pkg::BucketBits;
   localparam int HB = cbq_pkg::HeadBits;
   localparam int CB = cbq_pkg::CountBits;
   localparam int SB = cbq_pkg::SlotBits;
   localparam int TB = cbq_pkg::TotalBits;
   localparam int TmB = cbq_pkg::TimeBits;
   localparam int VB = cbq_pkg::ValueBits;
   localparam int MW = $bits(cbq_pkg::meta_type);

   cbq_pkg::req_type  req_ff;
   cbq_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BB-1:0]     earliest_ff, earliest_in;
   logic [TB-1:0]     total_ff, total_in;
   logic [HB-1:0]     head_e_ff;
   logic [BB-1:0]     clr_cnt_ff;

   logic [MW-1:0]     meta_rd_raw;
   cbq_pkg::meta_type meta_rd;
   logic              meta_rd_en;
   logic [BB-1:0]     meta_rd_addr;
   logic              meta_wr_en;
   logic [BB-1:0]     meta_wr_addr;
   cbq_pkg::meta_type meta_wr_data;

   logic [cbq_pkg::SlotWidth-1:0] slot_rd;
   logic [SB-1:0]                 slot_rd_addr;
   logic                          slot_wr_en;
   logic [SB-1:0]                 slot_wr_addr;

   logic [BB-1:0]  target_bucket;
   logic [TmB-1:0] req_time;
   logic [TmB-1:0] front_time;
   logic           is_pop;
   logic           queue_empty;
   logic           bucket_full;
   logic           push_ok;
   logic           pop_ok;
   logic [CB:0]    tail_sum;
   logic [HB-1:0]  tail_idx;
   logic [HB-1:0]  next_head;
   logic [1:0]     step_status;

   assign meta_rd     = cbq_pkg::meta_type'(meta_rd_raw);
   assign is_pop      = (req_ff.command == cbq_pkg::CmdPop);
   assign queue_empty = (total_ff == '0);
   assign req_time    = req_ff.item_time[TmB-1:0];
   assign front_time  = slot_rd[cbq_pkg::SlotWidth-1:VB];
   assign target_bucket = BB'(req_ff.item_time % cbq_pkg::NumBuckets);

   // Bucket fill state from the entry read in the lookup cycle
   assign bucket_full = (meta_rd.count >= CB'(cbq_pkg::BucketDepth));
   assign push_ok     = !is_pop && !bucket_full;
   assign pop_ok      = is_pop && !queue_empty;

   // Tail slot of the target bucket, wrapped once
   assign tail_sum = (CB + 1)'(meta_rd.head) + (CB + 1)'(meta_rd.count);
   assign tail_idx = (tail_sum >= (CB + 1)'(cbq_pkg::BucketDepth))
                   ? HB'(tail_sum - (CB + 1)'(cbq_pkg::BucketDepth))
                   : HB'(tail_sum);
   assign next_head = (meta_rd.head == HB'(cbq_pkg::BucketDepth - 1))
                    ? '0 : meta_rd.head + HB'(1);

   always_comb begin
      if (is_pop) begin
         step_status = queue_empty ? cbq_pkg::StatusEmpty : cbq_pkg::StatusOk;
      end else begin
         step_status = bucket_full ? cbq_pkg::StatusFull : cbq_pkg::StatusOk;
      end
   end

   // Bucket table read: target bucket on a push lookup, pointer otherwise
   assign meta_rd_en   = cmd.load_req | cmd.scan_read | cmd.lookup;
   assign meta_rd_addr = (cmd.lookup && !is_pop) ? target_bucket : earliest_ff;

   // Bucket table write: clearing sweep or step write-back
   always_comb begin
      meta_wr_en   = 1'b0;
      meta_wr_addr = clr_cnt_ff;
      meta_wr_data = '0;
      if (cmd.clear_write) begin
         meta_wr_en = 1'b1;
      end else if (cmd.commit && push_ok) begin
         meta_wr_en         = 1'b1;
         meta_wr_addr       = target_bucket;
         meta_wr_data.head  = meta_rd.head;
         meta_wr_data.count = meta_rd.count + CB'(1);
      end else if (cmd.commit && pop_ok) begin
         meta_wr_en         = 1'b1;
         meta_wr_addr       = earliest_ff;
         meta_wr_data.head  = next_head;
         meta_wr_data.count = meta_rd.count - CB'(1);
      end
   end

   // Slot store addresses
   assign slot_rd_addr = SB'(earliest_ff) * SB'(cbq_pkg::BucketDepth) + SB'(head_e_ff);
   assign slot_wr_addr = SB'(target_bucket) * SB'(cbq_pkg::BucketDepth) + SB'(tail_idx);
   assign slot_wr_en   = cmd.commit && push_ok;

   cbq_ram #(
      .WIDTH (MW),
      .DEPTH (cbq_pkg::NumBuckets)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_raw)
   );

   cbq_ram #(
      .WIDTH (cbq_pkg::SlotWidth),
      .DEPTH (cbq_pkg::SlotTotal)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data ({req_time, req_ff.item_value}),
      .rd_en   (cmd.lookup),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd)
   );

   // Pointer: step while scanning, retarget on a push earlier than the front
   always_comb begin
      earliest_in = earliest_ff;
      if (cmd.scan_step) begin
         earliest_in = (earliest_ff == BB'(cbq_pkg::NumBuckets - 1))
                     ? '0 : earliest_ff + BB'(1);
      end else if (cmd.commit && push_ok && (queue_empty || (front_time > req_time))) begin
         earliest_in = target_bucket;
      end
   end

   // Record count
   always_comb begin
      total_in = total_ff;
      if (cmd.commit && push_ok) begin
         total_in = total_ff + TB'(1);
      end else if (cmd.commit && pop_ok) begin
         total_in = total_ff - TB'(1);
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.commit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = step_status;
         rsp_in.out_time  = pop_ok ? 48'(front_time) : '0;
         rsp_in.out_value = pop_ok ? slot_rd[VB-1:0] : '0;
         rsp_in.occupancy = 14'(total_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         earliest_ff  <= '0;
         total_ff     <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         earliest_ff  <= earliest_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_write) begin
            clr_cnt_ff <= clr_cnt_ff + BB'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.scan_hit) begin
         head_e_ff <= meta_rd.head;
      end
      rsp_ff <= rsp_in;
   end

   assign stat.clear_done  = (clr_cnt_ff == BB'(cbq_pkg::NumBuckets - 1));
   assign stat.queue_empty = queue_empty;
   assign stat.bucket_busy = (meta_rd.count != '0);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/calendar_bucket_queue.sv
// Top level of the calendar bucket queue: controller plus datapath.
// Depends on cbq_pkg, cbq_ctrl, cbq_datapath and cbq_ram.
//
// Calendar queue of timestamped records: a push stores (time, value) in bucket
// time mod 1024, each bucket a FIFO of 8 entries; a pop returns the front of the
// earliest bucket. One transaction is in flight at a time, and each gives one
// response. After reset the block sweeps its 1024-entry bucket table, with
// req_ready low, before the first request is taken. An accepted request goes
// through a scan check of the pointer's bucket (skipped when the queue is
// empty), a lookup and a commit that loads the response; the next request is
// taken once the block is back in idle. Each empty bucket the pointer steps
// over adds a step and a re-read, since the single read port of the bucket
// table examines one bucket at a time. A waiting response does not stop the
// next request from being accepted; it only holds that request's write-back.
`default_nettype none

module calendar_bucket_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cbq_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cbq_pkg::rsp_type      rsp_payload
);

   cbq_pkg::ctl_cmd_type cmd;
   cbq_pkg::dp_stat_type stat;

   cbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Only one transaction is worked on at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // Write-back only when the response register can take it
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("commit while response register is blocked");

   // Occupancy never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.occupancy <= 14'(cbq_pkg::SlotTotal)))
      else $error("occupancy beyond capacity");

   // An empty-queue pop reports an empty queue and no record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == cbq_pkg::StatusEmpty))
      |-> ((rsp_payload.occupancy == '0) && (rsp_payload.out_time == '0)))
      else $error("empty status with records held");

endmodule

`default_nettype wire
